// ===== src/lru_block_cache_controller_top_assert.svh =====
// Assertion macros for the block cache controller.
// Needs no package; included by the top level only.
`ifndef LRU_BLOCK_CACHE_CONTROLLER_TOP_ASSERT_SVH
`define LRU_BLOCK_CACHE_CONTROLLER_TOP_ASSERT_SVH

// Same-cycle implication.
`define LBC_ASSERT_NOW(name, clk, rst, pre, post, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// Next-cycle implication.
`define LBC_ASSERT_NEXT(name, clk, rst, pre, post, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// ===== src/lbc_pkg.sv =====
// Shared constants, codes and types of the block cache controller.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package lbc_pkg;

   localparam int CacheEntries = 16;
   localparam int SlotBits     = $clog2(CacheEntries);
   localparam int OccBits      = $clog2(CacheEntries + 1);
   localparam int BlockBits    = 32;
   localparam logic [1:0] PrefetchReset = 2'd3;

   typedef enum logic [1:0] {
      MODE_READ  = 2'd0,
      MODE_WRITE = 2'd1,
      MODE_SYNC  = 2'd2,
      MODE_NONE  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ACT_SERVE     = 2'd0,
      ACT_WRITEBACK = 2'd1,
      ACT_FETCH     = 2'd2,
      ACT_SYNC_DONE = 2'd3
   } action_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_DECIDE,
      ST_VICTIM,
      ST_EVICT_WB,
      ST_LOAD,
      ST_SERVE,
      ST_SYNC_RD,
      ST_SYNC_WB,
      ST_SYNC_DONE
   } state_type;

   typedef logic [CacheEntries-1:0][SlotBits-1:0] order_type;

   typedef struct packed {
      logic                move;
      logic [SlotBits-1:0] move_pos;
      logic                grow;
      logic                set_valid;
      logic                set_dirty;
      logic                clr_dirty;
      logic [SlotBits-1:0] slot;
   } order_cmd_type;

   typedef struct packed {
      order_type               order;
      logic [CacheEntries-1:0] valid;
      logic [CacheEntries-1:0] dirty;
      logic [OccBits-1:0]      occupancy;
   } order_stat_type;

endpackage

// ===== src/lbc_tag_store.sv =====
// Tag memory: one block number per cache slot, synchronous read.
// Depends on lbc_pkg.
`timescale 1ns / 1ps

module lbc_tag_store (
   input  logic                         clock,
   input  logic                         rd_en,
   input  logic [lbc_pkg::SlotBits-1:0]  rd_addr,
   output logic [lbc_pkg::BlockBits-1:0] rd_data,
   input  logic                         wr_en,
   input  logic [lbc_pkg::SlotBits-1:0]  wr_addr,
   input  logic [lbc_pkg::BlockBits-1:0] wr_data
);
   import lbc_pkg::*;

   logic [BlockBits-1:0] mem [CacheEntries];
   logic [BlockBits-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/lbc_order.sv =====
// Recency list, valid and dirty marks and occupancy of the cache slots.
// Depends on lbc_pkg; driven by commands from the sequencer.
`timescale 1ns / 1ps

module lbc_order (
   input  logic                   clock,
   input  logic                   reset,
   input  lbc_pkg::order_cmd_type cmd,
   output lbc_pkg::order_stat_type stat
);
   import lbc_pkg::*;

   order_type               order_ff, order_in;
   logic [CacheEntries-1:0] valid_ff, valid_in;
   logic [CacheEntries-1:0] dirty_ff, dirty_in;
   logic [OccBits-1:0]      occ_ff, occ_in;

   // Moving position p to the front shifts positions 0..p-1 down by one.
   always_comb begin
      order_in = order_ff;
      valid_in = valid_ff;
      dirty_in = dirty_ff;
      occ_in   = occ_ff;
      if (cmd.move) begin
         order_in[0] = order_ff[cmd.move_pos];
         for (int i = 1; i < CacheEntries; i++) begin
            if (SlotBits'(i) <= cmd.move_pos) begin
               order_in[i] = order_ff[i-1];
            end
         end
      end
      if (cmd.grow) begin
         occ_in = occ_ff + OccBits'(1);
      end
      if (cmd.set_valid) begin
         valid_in[cmd.slot] = 1'b1;
      end
      if (cmd.clr_dirty) begin
         dirty_in[cmd.slot] = 1'b0;
      end
      if (cmd.set_dirty) begin
         dirty_in[cmd.slot] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CacheEntries; i++) begin
            order_ff[i] <= SlotBits'(i);
         end
         valid_ff <= '0;
         dirty_ff <= '0;
         occ_ff   <= '0;
      end else begin
         order_ff <= order_in;
         valid_ff <= valid_in;
         dirty_ff <= dirty_in;
         occ_ff   <= occ_in;
      end
   end

   assign stat.order     = order_ff;
   assign stat.valid     = valid_ff;
   assign stat.dirty     = dirty_ff;
   assign stat.occupancy = occ_ff;

endmodule

// ===== src/lbc_seq.sv =====
// Request sequencer: tag search, eviction, prefetch loads, serve and sync walk.
// Depends on lbc_pkg; drives the tag store and the recency list.
`timescale 1ns / 1ps

module lbc_seq (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [1:0]                    req_mode,
   input  logic [lbc_pkg::BlockBits-1:0] req_block,
   input  logic                          csr_write_enable,
   input  logic [1:0]                    csr_write_data,
   input  lbc_pkg::order_stat_type       stat,
   output lbc_pkg::order_cmd_type        cmd,
   output logic                          rd_en,
   output logic [lbc_pkg::SlotBits-1:0]  rd_addr,
   input  logic [lbc_pkg::BlockBits-1:0] rd_data,
   output logic                          wr_en,
   output logic [lbc_pkg::SlotBits-1:0]  wr_addr,
   output logic [lbc_pkg::BlockBits-1:0] wr_data,
   output logic                          rsp_valid,
   output logic [1:0]                    rsp_action,
   output logic [lbc_pkg::BlockBits-1:0] rsp_target_block,
   output logic [lbc_pkg::SlotBits-1:0]  rsp_slot,
   output logic                          rsp_hit,
   output logic                          rsp_last
);
   import lbc_pkg::*;

   state_type            state_ff, state_in;
   mode_type             mode_ff, mode_in;
   logic [BlockBits-1:0] blk_ff, blk_in;
   logic [BlockBits-1:0] tgt_ff, tgt_in;
   logic [1:0]           idx_ff, idx_in;
   logic [1:0]           cnt_ff, cnt_in;
   logic                 hit_ff, hit_in;
   logic                 found_ff, found_in;
   logic [SlotBits-1:0]  found_slot_ff, found_slot_in;
   logic [OccBits-1:0]   srch_ff, srch_in;
   logic                 cmp_vld_ff, cmp_vld_in;
   logic [SlotBits-1:0]  cmp_slot_ff, cmp_slot_in;
   logic [SlotBits-1:0]  main_slot_ff, main_slot_in;
   logic [OccBits-1:0]   q_ff, q_in;
   logic [SlotBits-1:0]  sync_slot_ff, sync_slot_in;
   logic [1:0]           pf_ff, pf_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   action_type           rsp_action_ff, rsp_action_in;
   logic [BlockBits-1:0] rsp_target_ff, rsp_target_in;
   logic [SlotBits-1:0]  rsp_slot_ff, rsp_slot_in;
   logic                 rsp_hit_ff, rsp_hit_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic                 full;
   logic [SlotBits-1:0]  victim_slot;
   logic [SlotBits-1:0]  load_slot;
   logic [SlotBits-1:0]  load_pos;
   logic                 victim_dirty;
   logic                 cmp_hit;
   logic [SlotBits-1:0]  main_pos;
   logic [SlotBits-1:0]  sync_slot;
   logic                 sync_dirty;
   logic [2:0]           next_idx;
   logic                 more;
   logic [BlockBits-1:0] next_tgt;
   mode_type             req_mode_e;

   assign req_mode_e   = mode_type'(req_mode);
   assign full         = (stat.occupancy == OccBits'(CacheEntries));
   assign victim_slot  = stat.order[CacheEntries-1];
   assign victim_dirty = full && stat.valid[victim_slot] && stat.dirty[victim_slot];
   assign load_slot    = full ? victim_slot : stat.order[stat.occupancy[SlotBits-1:0]];
   assign load_pos     = full ? SlotBits'(CacheEntries - 1) : stat.occupancy[SlotBits-1:0];
   assign cmp_hit      = cmp_vld_ff && stat.valid[cmp_slot_ff] && (rd_data == tgt_ff);
   assign sync_slot    = stat.order[q_ff[SlotBits-1:0]];
   assign sync_dirty   = stat.valid[sync_slot] && stat.dirty[sync_slot];
   assign next_idx     = {1'b0, idx_ff} + 3'd1;
   assign more         = (next_idx < {1'b0, cnt_ff});
   assign next_tgt     = blk_ff + BlockBits'(next_idx);

   always_comb begin
      main_pos = '0;
      for (int i = 0; i < CacheEntries; i++) begin
         if (stat.order[i] == main_slot_ff) begin
            main_pos = SlotBits'(i);
         end
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               priority if (req_mode_e == MODE_READ || req_mode_e == MODE_WRITE) begin
                  state_in = ST_SEARCH;
               end else if (req_mode_e == MODE_SYNC) begin
                  state_in = ST_SYNC_RD;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_SEARCH: begin
            if (srch_ff == OccBits'(CacheEntries)) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            priority if (!found_ff) begin
               state_in = ST_VICTIM;
            end else if (idx_ff != 2'd0 && more) begin
               state_in = ST_SEARCH;
            end else begin
               state_in = ST_SERVE;
            end
         end
         ST_VICTIM:   state_in = victim_dirty ? ST_EVICT_WB : ST_LOAD;
         ST_EVICT_WB: state_in = ST_LOAD;
         ST_LOAD:     state_in = more ? ST_SEARCH : ST_SERVE;
         ST_SERVE:    state_in = ST_IDLE;
         ST_SYNC_RD: begin
            priority if (q_ff == stat.occupancy) begin
               state_in = ST_SYNC_DONE;
            end else if (sync_dirty) begin
               state_in = ST_SYNC_WB;
            end else begin
               state_in = ST_SYNC_RD;
            end
         end
         ST_SYNC_WB:   state_in = ST_SYNC_RD;
         ST_SYNC_DONE: state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // Datapath, memory and list controls, and result register.
   always_comb begin
      mode_in       = mode_ff;
      blk_in        = blk_ff;
      tgt_in        = tgt_ff;
      idx_in        = idx_ff;
      cnt_in        = cnt_ff;
      hit_in        = hit_ff;
      found_in      = found_ff;
      found_slot_in = found_slot_ff;
      srch_in       = srch_ff;
      cmp_vld_in    = 1'b0;
      cmp_slot_in   = cmp_slot_ff;
      main_slot_in  = main_slot_ff;
      q_in          = q_ff;
      sync_slot_in  = sync_slot_ff;
      pf_in         = csr_write_enable ? csr_write_data : pf_ff;
      rd_en         = 1'b0;
      rd_addr       = '0;
      wr_en         = 1'b0;
      wr_addr       = load_slot;
      wr_data       = tgt_ff;
      cmd           = '0;
      rsp_valid_in  = 1'b0;
      rsp_action_in = rsp_action_ff;
      rsp_target_in = rsp_target_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_hit_in    = 1'b0;
      rsp_last_in   = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               mode_in = req_mode_e;
               blk_in  = req_block;
               tgt_in  = req_block;
               idx_in  = 2'd0;
               hit_in  = 1'b0;
               q_in    = '0;
               if (req_mode_e == MODE_WRITE || pf_ff == 2'd0) begin
                  cnt_in = 2'd1;
               end else begin
                  cnt_in = pf_ff;
               end
            end
         end
         ST_SEARCH: begin
            // Tag read issued for one slot a cycle, compared the cycle after.
            if (srch_ff != OccBits'(CacheEntries)) begin
               rd_en       = 1'b1;
               rd_addr     = srch_ff[SlotBits-1:0];
               cmp_vld_in  = 1'b1;
               cmp_slot_in = srch_ff[SlotBits-1:0];
               srch_in     = srch_ff + OccBits'(1);
            end
            if (cmp_hit) begin
               found_in      = 1'b1;
               found_slot_in = cmp_slot_ff;
            end
         end
         ST_DECIDE: begin
            if (found_ff) begin
               if (idx_ff == 2'd0) begin
                  hit_in       = 1'b1;
                  main_slot_in = found_slot_ff;
               end else if (more) begin
                  idx_in = next_idx[1:0];
                  tgt_in = next_tgt;
               end
            end
         end
         ST_VICTIM: begin
            if (victim_dirty) begin
               rd_en   = 1'b1;
               rd_addr = victim_slot;
            end
         end
         ST_EVICT_WB: begin
            rsp_valid_in  = 1'b1;
            rsp_action_in = ACT_WRITEBACK;
            rsp_target_in = rd_data;
            rsp_slot_in   = victim_slot;
         end
         ST_LOAD: begin
            wr_en         = 1'b1;
            cmd.move      = 1'b1;
            cmd.move_pos  = load_pos;
            cmd.grow      = !full;
            cmd.set_valid = 1'b1;
            cmd.clr_dirty = 1'b1;
            cmd.slot      = load_slot;
            rsp_valid_in  = 1'b1;
            rsp_action_in = ACT_FETCH;
            rsp_target_in = tgt_ff;
            rsp_slot_in   = load_slot;
            if (idx_ff == 2'd0) begin
               main_slot_in = load_slot;
            end
            if (more) begin
               idx_in = next_idx[1:0];
               tgt_in = next_tgt;
            end
         end
         ST_SERVE: begin
            cmd.move      = 1'b1;
            cmd.move_pos  = main_pos;
            cmd.set_dirty = (mode_ff == MODE_WRITE);
            cmd.slot      = main_slot_ff;
            rsp_valid_in  = 1'b1;
            rsp_action_in = ACT_SERVE;
            rsp_target_in = blk_ff;
            rsp_slot_in   = main_slot_ff;
            rsp_hit_in    = hit_ff;
            rsp_last_in   = 1'b1;
         end
         ST_SYNC_RD: begin
            if (q_ff != stat.occupancy) begin
               if (sync_dirty) begin
                  rd_en        = 1'b1;
                  rd_addr      = sync_slot;
                  sync_slot_in = sync_slot;
               end else begin
                  q_in = q_ff + OccBits'(1);
               end
            end
         end
         ST_SYNC_WB: begin
            cmd.clr_dirty = 1'b1;
            cmd.slot      = sync_slot_ff;
            q_in          = q_ff + OccBits'(1);
            rsp_valid_in  = 1'b1;
            rsp_action_in = ACT_WRITEBACK;
            rsp_target_in = rd_data;
            rsp_slot_in   = sync_slot_ff;
         end
         ST_SYNC_DONE: begin
            rsp_valid_in  = 1'b1;
            rsp_action_in = ACT_SYNC_DONE;
            rsp_target_in = '0;
            rsp_slot_in   = '0;
            rsp_last_in   = 1'b1;
         end
         default: begin
         end
      endcase

      // Every new tag search starts from slot zero with nothing found.
      if (state_in == ST_SEARCH && state_ff != ST_SEARCH) begin
         srch_in    = '0;
         found_in   = 1'b0;
         cmp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pf_ff        <= PrefetchReset;
      end else begin
         state_ff     <= state_in;
         cmp_vld_ff   <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         pf_ff        <= pf_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      blk_ff        <= blk_in;
      tgt_ff        <= tgt_in;
      idx_ff        <= idx_in;
      cnt_ff        <= cnt_in;
      hit_ff        <= hit_in;
      found_ff      <= found_in;
      found_slot_ff <= found_slot_in;
      srch_ff       <= srch_in;
      cmp_slot_ff   <= cmp_slot_in;
      main_slot_ff  <= main_slot_in;
      q_ff          <= q_in;
      sync_slot_ff  <= sync_slot_in;
      rsp_action_ff <= rsp_action_in;
      rsp_target_ff <= rsp_target_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_action       = rsp_action_ff;
   assign rsp_target_block = rsp_target_ff;
   assign rsp_slot         = rsp_slot_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_last         = rsp_last_ff;

endmodule

// ===== src/lru_block_cache_controller_top.sv =====
// Fully associative write-back block cache controller, 16 slots, LRU
// replacement with sequential prefetch on read misses. A transaction is taken
// when start is high and busy is low; results come one per strobe of rsp_valid
// and cannot be held off, so the receiver must take each one in its cycle.
// Every tag search walks the tag memory one slot per cycle; a load is
// preceded by a write-back of the victim when it is dirty, each further
// prefetch block takes its own tag search, and a sync walks the occupied
// slots in recency order and writes back each dirty one.
// Depends on lbc_pkg, lbc_tag_store, lbc_order and lbc_seq.
`timescale 1ns / 1ps
`include "lru_block_cache_controller_top_assert.svh"

module lru_block_cache_controller_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [1:0]                    req_mode,
   input  logic [lbc_pkg::BlockBits-1:0] req_block,
   input  logic                          csr_write_enable,
   input  logic [1:0]                    csr_write_data,
   output logic                          rsp_valid,
   output logic [1:0]                    rsp_action,
   output logic [lbc_pkg::BlockBits-1:0] rsp_target_block,
   output logic [lbc_pkg::SlotBits-1:0]  rsp_slot,
   output logic                          rsp_hit,
   output logic                          rsp_last
);
   import lbc_pkg::*;

   order_cmd_type        cmd;
   order_stat_type       stat;
   logic                 rd_en;
   logic [SlotBits-1:0]  rd_addr;
   logic [BlockBits-1:0] rd_data;
   logic                 wr_en;
   logic [SlotBits-1:0]  wr_addr;
   logic [BlockBits-1:0] wr_data;

   lbc_tag_store u_tags (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   lbc_order u_order (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .stat  (stat)
   );

   lbc_seq u_seq (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_mode         (req_mode),
      .req_block        (req_block),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .stat             (stat),
      .cmd              (cmd),
      .rd_en            (rd_en),
      .rd_addr          (rd_addr),
      .rd_data          (rd_data),
      .wr_en            (wr_en),
      .wr_addr          (wr_addr),
      .wr_data          (wr_data),
      .rsp_valid        (rsp_valid),
      .rsp_action       (rsp_action),
      .rsp_target_block (rsp_target_block),
      .rsp_slot         (rsp_slot),
      .rsp_hit          (rsp_hit),
      .rsp_last         (rsp_last)
   );

   `LBC_ASSERT_NEXT(a_last_ends_burst, clock, reset, rsp_valid && rsp_last, !rsp_valid, "result after the final result of a transaction")
   `LBC_ASSERT_NOW(a_idle_only_last, clock, reset, !busy, !rsp_valid || rsp_last, "non-final result while idle")
   `LBC_ASSERT_NEXT(a_start_busy, clock, reset, start && !busy && req_mode != MODE_NONE, busy, "accepted transaction did not make the block busy")
   `LBC_ASSERT_NOW(a_fetch_not_last, clock, reset, rsp_valid && rsp_action == ACT_FETCH, !rsp_last, "fetch marked as final result")

endmodule
